>>> rtl/life3_pkg.sv
// Package for the 3D life block: constants, state codes, the stage flag struct
// and the neighbor-phase offset table. No dependencies.
package life3_pkg;

  localparam int unsigned GRID_SIDE_DEF    = 32;
  localparam int unsigned PATTERN_SIDE_DEF = 16;

  localparam int unsigned CELL_W  = 4;
  localparam int unsigned GEN_W   = 4;
  localparam int unsigned TOTAL_W = 16;
  localparam logic [GEN_W-1:0] GEN_RESET = 4'd6;

  // Neighborhood sum over the 3x3x3 cube, the cell itself included (0..27).
  localparam int unsigned ACC_W = 5;
  localparam logic [ACC_W-1:0] ACC_BIRTH = 5'd3;
  // With the cell itself counted, a live cell with three neighbors sums to four.
  localparam logic [ACC_W-1:0] ACC_STAY  = 5'd4;

  localparam int unsigned PH_W = 4;
  localparam logic [PH_W-1:0] PH_CENTER = 4'd4;
  localparam logic [PH_W-1:0] PH_LAST   = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEN,
    ST_DRAIN,
    ST_COUNT,
    ST_CFLUSH,
    ST_SUM,
    ST_DONE
  } state_e;

  // Flags that travel with one row read of the generation sweep.
  typedef struct packed {
    logic vld;
    logic oob;
    logic first;
    logic center;
    logic last;
  } tap_t;

  // Two-bit signed offset (-1, 0, +1) of a phase along x.
  function automatic logic [1:0] phase_dx(input logic [PH_W-1:0] ph);
    logic [1:0] d;
    unique case (ph)
      4'd0, 4'd1, 4'd2: d = 2'b11;
      4'd3, 4'd4, 4'd5: d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  // Two-bit signed offset (-1, 0, +1) of a phase along y.
  function automatic logic [1:0] phase_dy(input logic [PH_W-1:0] ph);
    logic [1:0] d;
    unique case (ph)
      4'd0, 4'd3, 4'd6: d = 2'b11;
      4'd1, 4'd4, 4'd7: d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/life3_mem.sv
// Synchronous single-write, single-read grid row memory with per-bit write mask.
// Read data is registered (old data on a same-address write).
module life3_mem #(
  parameter int unsigned WIDTH = life3_pkg::GRID_SIDE_DEF,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [WIDTH-1:0]  wmask_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) begin
          mem[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

>>> rtl/life3_lanes.sv
// Per-z neighbor accumulation and life rule over one grid row.
// Depends on life3_pkg (tap_t, accumulator width and rule constants).
module life3_lanes #(
  parameter int unsigned GRID_SIDE = life3_pkg::GRID_SIDE_DEF
) (
  input  logic                 clk_i,
  input  life3_pkg::tap_t      tap_i,
  input  logic [GRID_SIDE-1:0] row_i,
  output logic                 wr_o,
  output logic [GRID_SIDE-1:0] row_o
);

  logic [GRID_SIDE-1:0]     row_m;
  logic [GRID_SIDE+1:0]     row_pad;
  logic [GRID_SIDE-1:0]     self_q;
  logic [life3_pkg::ACC_W-1:0] acc_q [GRID_SIDE];
  logic [life3_pkg::ACC_W-1:0] acc_d [GRID_SIDE];

  // Rows beyond the grid edge count as empty.
  assign row_m   = tap_i.oob ? '0 : row_i;
  assign row_pad = {1'b0, row_m, 1'b0};

  for (genvar z = 0; z < GRID_SIDE; z++) begin : g_lane
    logic [1:0] win;
    logic       self_bit;

    assign win = 2'(row_pad[z]) + 2'(row_pad[z+1]) + 2'(row_pad[z+2]);
    assign acc_d[z] = (tap_i.first ? '0 : acc_q[z]) + life3_pkg::ACC_W'(win);
    assign self_bit = tap_i.center ? row_m[z] : self_q[z];
    assign row_o[z] = (acc_d[z] == life3_pkg::ACC_BIRTH) ||
                      (self_bit && (acc_d[z] == life3_pkg::ACC_STAY));

    always_ff @(posedge clk_i) begin
      if (tap_i.vld) begin
        acc_q[z] <= acc_d[z];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_i.vld && tap_i.center) begin
      self_q <= row_m;
    end
  end

  assign wr_o = tap_i.vld && tap_i.last;

endmodule

>>> rtl/life3_tally.sv
// Active-cell tally: per-z column counters filled row by row, then on shift_i
// shifted out one per cycle into a saturating 16-bit total. Uses life3_pkg.
module life3_tally #(
  parameter int unsigned GRID_SIDE = life3_pkg::GRID_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          add_i,
  input  logic [GRID_SIDE-1:0]          row_i,
  input  logic                          shift_i,
  output logic [life3_pkg::TOTAL_W-1:0] total_o
);

  localparam int unsigned LW = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam int unsigned SW = life3_pkg::TOTAL_W + 1;

  logic [LW-1:0] cnt_q [GRID_SIDE];
  logic [life3_pkg::TOTAL_W-1:0] total_q;
  logic [SW-1:0] sum;

  assign sum = SW'(total_q) + SW'(cnt_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < GRID_SIDE; z++) begin
        cnt_q[z] <= '0;
      end
      total_q <= '0;
    end else begin
      priority if (clr_i) begin
        for (int z = 0; z < GRID_SIDE; z++) begin
          cnt_q[z] <= '0;
        end
        total_q <= '0;
      end else if (add_i) begin
        for (int z = 0; z < GRID_SIDE; z++) begin
          cnt_q[z] <= cnt_q[z] + LW'(row_i[z]);
        end
      end else if (shift_i) begin
        for (int z = 0; z < GRID_SIDE - 1; z++) begin
          cnt_q[z] <= cnt_q[z+1];
        end
        cnt_q[GRID_SIDE-1] <= '0;
        total_q <= sum[SW-1] ? '1 : sum[life3_pkg::TOTAL_W-1:0];
      end
    end
  end

  assign total_o = total_q;

endmodule

>>> rtl/life_3d_automaton.sv
// Top level of the bounded 3D life block: sequencer, two row memories,
// neighbor lanes and the active-cell tally. Depends on life3_pkg and submodules.
//
// Usage: pattern cells are requests on start_i with cell_row_i, cell_col_i,
// cell_active_i and last_cell_i; a request is taken at an edge where start_i is
// high and busy_o is low. Active cells go into the middle z plane of a
// GRID_SIDE^3 bit grid, one request per cycle while busy_o stays low.
// The grid is held as GRID_SIDE^2 rows of GRID_SIDE bits (one row per x, y)
// in two memories that swap roles each generation.
// A request with last_cell_i raises busy_o and runs cfg_wdata_i generations
// (register reset value 6). Each generation walks every row with nine
// reads, one per cycle through the current memory's single read port, and
// then a drain state. The count pass then reads and clears every row; a
// flush state and a sum state follow that add the column counters into the
// total. done_o pulses for one cycle with active_total_o, saturated at
// 65535, and busy_o drops on the next cycle.
// After reset busy_o stays high while the grid is cleared; cfg writes are
// still taken then. The receiver cannot stall, so the result must be taken
// in the cycle done_o is high.
module life_3d_automaton #(
  parameter int unsigned GRID_SIDE    = life3_pkg::GRID_SIDE_DEF,
  parameter int unsigned PATTERN_SIDE = life3_pkg::PATTERN_SIDE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [life3_pkg::CELL_W-1:0]    cell_row_i,
  input  logic [life3_pkg::CELL_W-1:0]    cell_col_i,
  input  logic                            cell_active_i,
  input  logic                            last_cell_i,
  input  logic                            cfg_we_i,
  input  logic [life3_pkg::GEN_W-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output logic [life3_pkg::TOTAL_W-1:0]   active_total_o
);

  localparam int unsigned AW  = $clog2(GRID_SIDE);
  localparam int unsigned AAW = 2 * AW;
  localparam int unsigned PW  = ((AW > 5) ? AW : 5) + 1;
  localparam int unsigned OFF = (GRID_SIDE >= PATTERN_SIDE) ?
                                (GRID_SIDE - PATTERN_SIDE) / 2 : 0;
  localparam int unsigned ZMID = GRID_SIDE / 2;
  localparam logic [AW-1:0] LAST_C = AW'(GRID_SIDE - 1);
  localparam logic [GRID_SIDE-1:0] LOAD_MASK = {{(GRID_SIDE-1){1'b0}}, 1'b1} << ZMID;

  life3_pkg::state_e state_q, state_d;
  logic                          sel_q, sel_d;
  logic [AW-1:0]                 x_q, x_d, y_q, y_d, z_q, z_d;
  logic [life3_pkg::PH_W-1:0]    ph_q, ph_d;
  logic [life3_pkg::GEN_W-1:0]   gen_q, gen_d, gen_inc;
  logic [life3_pkg::GEN_W-1:0]   gen_cfg_q;
  life3_pkg::tap_t               tap_q, tap_d;
  logic [AAW-1:0]                tgt_q, tgt_d;
  logic                          cvld_q, cvld_d;

  logic          accept, load_ok, xy_last;
  logic [AW-1:0] x_step, y_step;
  logic [PW-1:0] x_ld, y_ld;
  logic [AW:0]   nx, ny;
  logic          oob;

  logic                 cur_we;
  logic [AAW-1:0]       cur_addr, rd_addr;
  logic [GRID_SIDE-1:0] cur_data, cur_mask;
  logic                 nxt_we;
  logic [GRID_SIDE-1:0] nxt_row;
  logic [GRID_SIDE-1:0] rd0, rd1, cur_rd;

  assign accept = start_i && (state_q == life3_pkg::ST_IDLE);
  assign x_ld = PW'(cell_row_i) + PW'(OFF);
  assign y_ld = PW'(cell_col_i) + PW'(OFF);
  assign load_ok = cell_active_i &&
                   (PW'(cell_row_i) < PW'(PATTERN_SIDE)) &&
                   (PW'(cell_col_i) < PW'(PATTERN_SIDE)) &&
                   (x_ld < PW'(GRID_SIDE)) && (y_ld < PW'(GRID_SIDE));

  // Row walk in (x, y) order.
  assign xy_last = (x_q == LAST_C) && (y_q == LAST_C);
  assign y_step  = (y_q == LAST_C) ? '0 : y_q + 1'b1;
  assign x_step  = (y_q == LAST_C) ? ((x_q == LAST_C) ? '0 : x_q + 1'b1) : x_q;

  // Neighbor row of the current phase; -1 wraps to a large value and reads as out of grid.
  always_comb begin
    logic [1:0] dx, dy;
    dx = life3_pkg::phase_dx(ph_q);
    dy = life3_pkg::phase_dy(ph_q);
    nx = {1'b0, x_q} + {{(AW-1){dx[1]}}, dx};
    ny = {1'b0, y_q} + {{(AW-1){dy[1]}}, dy};
  end
  assign oob = (nx >= (AW+1)'(GRID_SIDE)) || (ny >= (AW+1)'(GRID_SIDE));
  assign gen_inc = gen_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    ph_d     = ph_q;
    gen_d    = gen_q;
    tap_d    = '0;
    tgt_d    = tgt_q;
    cvld_d   = 1'b0;
    cur_we   = 1'b0;
    cur_addr = {x_q, y_q};
    cur_data = '0;
    cur_mask = '1;
    rd_addr  = {x_q, y_q};

    unique case (state_q)
      life3_pkg::ST_CLEAR: begin
        cur_we = 1'b1;
        x_d = x_step;
        y_d = y_step;
        if (xy_last) begin
          state_d = life3_pkg::ST_IDLE;
        end
      end
      life3_pkg::ST_IDLE: begin
        if (accept) begin
          cur_we   = load_ok;
          cur_addr = {x_ld[AW-1:0], y_ld[AW-1:0]};
          cur_data = '1;
          cur_mask = LOAD_MASK;
          if (last_cell_i) begin
            x_d   = '0;
            y_d   = '0;
            ph_d  = '0;
            gen_d = '0;
            state_d = (gen_cfg_q == '0) ? life3_pkg::ST_COUNT : life3_pkg::ST_GEN;
          end
        end
      end
      life3_pkg::ST_GEN: begin
        rd_addr = {nx[AW-1:0], ny[AW-1:0]};
        tap_d.vld    = 1'b1;
        tap_d.oob    = oob;
        tap_d.first  = (ph_q == '0);
        tap_d.center = (ph_q == life3_pkg::PH_CENTER);
        tap_d.last   = (ph_q == life3_pkg::PH_LAST);
        tgt_d = {x_q, y_q};
        if (ph_q == life3_pkg::PH_LAST) begin
          ph_d = '0;
          x_d  = x_step;
          y_d  = y_step;
          if (xy_last) begin
            state_d = life3_pkg::ST_DRAIN;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      life3_pkg::ST_DRAIN: begin
        // The last row write lands this cycle; the memories swap roles after it.
        sel_d = ~sel_q;
        if (gen_inc == gen_cfg_q) begin
          gen_d   = '0;
          state_d = life3_pkg::ST_COUNT;
        end else begin
          gen_d   = gen_inc;
          state_d = life3_pkg::ST_GEN;
        end
      end
      life3_pkg::ST_COUNT: begin
        // Each row is read and cleared in the same cycle.
        cur_we = 1'b1;
        cvld_d = 1'b1;
        x_d = x_step;
        y_d = y_step;
        if (xy_last) begin
          state_d = life3_pkg::ST_CFLUSH;
        end
      end
      life3_pkg::ST_CFLUSH: begin
        z_d = '0;
        state_d = life3_pkg::ST_SUM;
      end
      life3_pkg::ST_SUM: begin
        z_d = z_q + 1'b1;
        if (z_q == LAST_C) begin
          state_d = life3_pkg::ST_DONE;
        end
      end
      life3_pkg::ST_DONE: begin
        state_d = life3_pkg::ST_IDLE;
      end
      default: begin
        state_d = life3_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= life3_pkg::ST_CLEAR;
      sel_q     <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      ph_q      <= '0;
      gen_q     <= '0;
      gen_cfg_q <= life3_pkg::GEN_RESET;
      tap_q     <= '0;
      cvld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      ph_q    <= ph_d;
      gen_q   <= gen_d;
      tap_q   <= tap_d;
      cvld_q  <= cvld_d;
      if (cfg_we_i) begin
        gen_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
  end

  life3_mem #(.WIDTH(GRID_SIDE), .ADDR_W(AAW)) u_mem0 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? nxt_we : cur_we),
    .waddr_i (sel_q ? tgt_q : cur_addr),
    .wdata_i (sel_q ? nxt_row : cur_data),
    .wmask_i (sel_q ? '1 : cur_mask),
    .raddr_i (rd_addr),
    .rdata_o (rd0)
  );

  life3_mem #(.WIDTH(GRID_SIDE), .ADDR_W(AAW)) u_mem1 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? cur_we : nxt_we),
    .waddr_i (sel_q ? cur_addr : tgt_q),
    .wdata_i (sel_q ? cur_data : nxt_row),
    .wmask_i (sel_q ? cur_mask : '1),
    .raddr_i (rd_addr),
    .rdata_o (rd1)
  );

  assign cur_rd = sel_q ? rd1 : rd0;

  life3_lanes #(.GRID_SIDE(GRID_SIDE)) u_lanes (
    .clk_i (clk_i),
    .tap_i (tap_q),
    .row_i (cur_rd),
    .wr_o  (nxt_we),
    .row_o (nxt_row)
  );

  life3_tally #(.GRID_SIDE(GRID_SIDE)) u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (state_q == life3_pkg::ST_DONE),
    .add_i   (cvld_q),
    .row_i   (cur_rd),
    .shift_i (state_q == life3_pkg::ST_SUM),
    .total_o (active_total_o)
  );

  assign busy_o = (state_q != life3_pkg::ST_IDLE);
  assign done_o = (state_q == life3_pkg::ST_DONE);

endmodule

>>> rtl/life3_checker.sv
// Port-level checks for the 3D life block, bound to the top level.
// Depends only on the top level's ports.
module life3_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_cell_i,
  input logic done_o
);

  // A result is only given while a run is in progress.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o without busy_o");

  // The result closes the run: the block is free on the next cycle.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy_o still high after done_o");

  // The final pattern cell starts a run.
  a_last_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_cell_i) |=> busy_o)
    else $error("last cell request did not start a run");

  // Other pattern cells load and keep the block free.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_cell_i) |=> (!busy_o && !done_o))
    else $error("pattern cell request made the block busy");

endmodule

bind life_3d_automaton life3_checker u_life3_checker (.*);
